// File: rtl/esipc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package esipc_pkg;

   localparam int MAX_ITEMS_DEF   = 2048;
   localparam int HIST_DEPTH_DEF  = 65536;
   localparam int VALUE_WIDTH_DEF = 16;

   localparam int VALUE_PORT_W = 16;
   localparam int HIST_W       = 22;
   localparam int TOTAL_W      = 42;
   localparam int PAIR_W       = 41;
   localparam int STATUS_W     = 2;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_TOO_LONG = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_SUM_OVF  = 2'd2;

   typedef enum logic [6:0] {
      ST_INIT   = 7'b0000001,
      ST_LOAD   = 7'b0000010,
      ST_WALK   = 7'b0000100,
      ST_WDRAIN = 7'b0001000,
      ST_SWEEP  = 7'b0010000,
      ST_SDRAIN = 7'b0100000,
      ST_EMIT   = 7'b1000000
   } state_type;

endpackage

`default_nettype wire

// File: rtl/esipc_prefix_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module esipc_prefix_mem #(
   parameter int DEPTH = 2048,
   parameter int AW    = 11,
   parameter int DW    = 16
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [DW-1:0] wr_data,
   input  wire logic [AW-1:0] rd_addr_a,
   input  wire logic [AW-1:0] rd_addr_b,
   output logic      [DW-1:0] rd_data_a,
   output logic      [DW-1:0] rd_data_b
);

   logic [DW-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

`default_nettype wire

// File: rtl/esipc_hist_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module esipc_hist_mem #(
   parameter int DEPTH = 65536,
   parameter int AW    = 16
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [AW-1:0]              wr_addr,
   input  wire logic [esipc_pkg::HIST_W-1:0] wr_data,
   input  wire logic [AW-1:0]              rd_addr,
   output logic      [esipc_pkg::HIST_W-1:0] rd_data
);
   import esipc_pkg::*;

   logic [HIST_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// File: rtl/equal_sum_interval_pair_counter_unit.sv
// loading: the N words of a sequence are accepted only while in the load state
// after the last word: N*(N-1)/2 intervals of two or more words walk the prefix memory,
// then all HIST_DEPTH histogram entries are read and cleared, followed by drain and emit
// an error sequence or one with fewer than two words goes from load straight to emit
// throughput: one sequence at a time, set by the single histogram read-modify-write port
// reset: synchronous; a clearing pass zeroes all HIST_DEPTH histogram entries, req_ready low
`timescale 1ns / 1ps
`default_nettype none

module equal_sum_interval_pair_counter_unit #(
   parameter int MAX_ITEMS   = esipc_pkg::MAX_ITEMS_DEF,
   parameter int HIST_DEPTH  = esipc_pkg::HIST_DEPTH_DEF,
   parameter int VALUE_WIDTH = esipc_pkg::VALUE_WIDTH_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [esipc_pkg::VALUE_PORT_W-1:0] req_value,
   input  wire logic                               req_last,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic      [esipc_pkg::PAIR_W-1:0]       rsp_pair_count,
   output logic      [esipc_pkg::STATUS_W-1:0]     rsp_status
);
   import esipc_pkg::*;

   localparam int AW  = $clog2(MAX_ITEMS);
   localparam int CW  = $clog2(MAX_ITEMS + 1);
   localparam int HW  = $clog2(HIST_DEPTH);
   localparam int MW1 = (HW > VALUE_WIDTH) ? HW : VALUE_WIDTH;
   localparam int MW2 = (MW1 > VALUE_PORT_W) ? MW1 : VALUE_PORT_W;
   localparam int SW  = MW2 + 1;
   localparam int PW  = 2 * HIST_W;

   state_type state_ff, state_in;

   logic [CW-1:0]      count_ff, count_in;
   logic               len_err_ff, len_err_in;
   logic               ovf_err_ff, ovf_err_in;
   logic [HW-1:0]      prev_ff, prev_in;
   logic [AW-1:0]      i_ff, i_in;
   logic [AW-1:0]      j_ff, j_in;
   logic [HW-1:0]      b_ff, b_in;
   logic               s1_vld_ff, s1_vld_in;
   logic               s1_i0_ff, s1_i0_in;
   logic               s2_vld_ff;
   logic [HW-1:0]      s2_addr_ff;
   logic               fw_vld_ff;
   logic [HW-1:0]      fw_addr_ff;
   logic [HIST_W-1:0]  fw_data_ff;
   logic               sw1_vld_ff, sw1_vld_in;
   logic [HW-1:0]      sw1_addr_ff;
   logic               sw2_vld_ff;
   logic [PW-1:0]      prod_ff;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [PAIR_W-1:0]  rsp_pair_ff, rsp_pair_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic               req_fire;
   logic [SW-1:0]      vm;
   logic [SW-1:0]      psum;
   logic               pre_we;
   logic [HW-1:0]      pre_rd_a, pre_rd_b;
   logic [HW-1:0]      sum_s;
   logic               h_we;
   logic [HW-1:0]      h_waddr, h_raddr;
   logic [HIST_W-1:0]  h_wdata, h_rdata;
   logic [HIST_W-1:0]  k_old;
   logic               emit_fire;
   logic               len_next, ovf_next;
   logic [CW-1:0]      count_next;

   assign req_ready = (state_ff == ST_LOAD);
   assign req_fire  = req_valid && req_ready;

   assign vm   = {{(SW-VALUE_PORT_W){1'b0}}, req_value} & ({SW{1'b1}} >> (SW - VALUE_WIDTH));
   assign psum = ((count_ff == '0) ? '0 : {{(SW-HW){1'b0}}, prev_ff}) + vm;

   assign pre_we = req_fire && (count_ff < CW'(MAX_ITEMS));

   always_comb begin
      len_next   = len_err_ff;
      ovf_next   = ovf_err_ff;
      count_next = count_ff;
      prev_in    = prev_ff;
      if (req_fire) begin
         if (count_ff >= CW'(MAX_ITEMS)) begin
            len_next = 1'b1;
         end else begin
            count_next = count_ff + CW'(1);
            prev_in    = psum[HW-1:0];
            if (psum > SW'(HIST_DEPTH - 1)) begin
               ovf_next = 1'b1;
            end
         end
      end
   end

   esipc_prefix_mem #(.DEPTH(MAX_ITEMS), .AW(AW), .DW(HW)) u_prefix (
      .clock     (clock),
      .wr_en     (pre_we),
      .wr_addr   (count_ff[AW-1:0]),
      .wr_data   (psum[HW-1:0]),
      .rd_addr_a (j_ff),
      .rd_addr_b (i_ff - AW'(1)),
      .rd_data_a (pre_rd_a),
      .rd_data_b (pre_rd_b)
   );

   // interval sum from prefix pair
   assign sum_s = pre_rd_a - (s1_i0_ff ? '0 : pre_rd_b);
   assign k_old = (fw_vld_ff && (fw_addr_ff == s2_addr_ff)) ? fw_data_ff : h_rdata;

   always_comb begin
      h_we    = 1'b0;
      h_waddr = b_ff;
      h_wdata = '0;
      h_raddr = (state_ff == ST_SWEEP) ? b_ff : sum_s;
      if (state_ff == ST_INIT) begin
         h_we = 1'b1;
      end else if (s2_vld_ff) begin
         h_we    = 1'b1;
         h_waddr = s2_addr_ff;
         h_wdata = k_old + HIST_W'(1);
      end else if (sw1_vld_ff) begin
         h_we    = 1'b1;
         h_waddr = sw1_addr_ff;
      end
   end

   esipc_hist_mem #(.DEPTH(HIST_DEPTH), .AW(HW)) u_hist (
      .clock   (clock),
      .wr_en   (h_we),
      .wr_addr (h_waddr),
      .wr_data (h_wdata),
      .rd_addr (h_raddr),
      .rd_data (h_rdata)
   );

   assign emit_fire = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_next;
      len_err_in    = len_next;
      ovf_err_in    = ovf_next;
      i_in          = i_ff;
      j_in          = j_ff;
      b_in          = b_ff;
      s1_vld_in     = 1'b0;
      s1_i0_in      = (i_ff == '0);
      sw1_vld_in    = 1'b0;
      total_in      = total_ff;
      rsp_pair_in   = rsp_pair_ff;
      rsp_status_in = rsp_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      if (sw2_vld_ff) begin
         total_in = total_ff + TOTAL_W'(prod_ff >> 1);
      end
      unique case (state_ff)
         ST_INIT: begin
            b_in = b_ff + HW'(1);
            if (b_ff == HW'(HIST_DEPTH - 1)) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (req_fire && req_last) begin
               total_in = '0;
               i_in     = '0;
               j_in     = AW'(1);
               if (len_next || ovf_next || (count_next < CW'(2))) begin
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            s1_vld_in = 1'b1;
            if (j_ff == AW'(count_ff - CW'(1))) begin
               if (i_ff == AW'(count_ff - CW'(2))) begin
                  state_in = ST_WDRAIN;
               end else begin
                  i_in = i_ff + AW'(1);
                  j_in = i_ff + AW'(2);
               end
            end else begin
               j_in = j_ff + AW'(1);
            end
         end
         ST_WDRAIN: begin
            b_in = '0;
            if (!s1_vld_ff && !s2_vld_ff) begin
               state_in = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            sw1_vld_in = 1'b1;
            b_in       = b_ff + HW'(1);
            if (b_ff == HW'(HIST_DEPTH - 1)) begin
               state_in = ST_SDRAIN;
            end
         end
         ST_SDRAIN: begin
            if (!sw1_vld_ff && !sw2_vld_ff) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (emit_fire) begin
               rsp_valid_in = 1'b1;
               if (len_err_ff) begin
                  rsp_status_in = STATUS_TOO_LONG;
                  rsp_pair_in   = '0;
               end else if (ovf_err_ff) begin
                  rsp_status_in = STATUS_SUM_OVF;
                  rsp_pair_in   = '0;
               end else begin
                  rsp_status_in = STATUS_OK;
                  rsp_pair_in   = total_ff[PAIR_W-1:0];
               end
               count_in   = '0;
               len_err_in = 1'b0;
               ovf_err_in = 1'b0;
               state_in   = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         count_ff     <= '0;
         len_err_ff   <= 1'b0;
         ovf_err_ff   <= 1'b0;
         b_ff         <= '0;
         s1_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         fw_vld_ff    <= 1'b0;
         sw1_vld_ff   <= 1'b0;
         sw2_vld_ff   <= 1'b0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         len_err_ff   <= len_err_in;
         ovf_err_ff   <= ovf_err_in;
         b_ff         <= b_in;
         s1_vld_ff    <= s1_vld_in;
         s2_vld_ff    <= s1_vld_ff;
         fw_vld_ff    <= s2_vld_ff;
         sw1_vld_ff   <= sw1_vld_in;
         sw2_vld_ff   <= sw1_vld_ff;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prev_ff       <= prev_in;
      i_ff          <= i_in;
      j_ff          <= j_in;
      s1_i0_ff      <= s1_i0_in;
      s2_addr_ff    <= sum_s;
      fw_addr_ff    <= s2_addr_ff;
      fw_data_ff    <= h_wdata;
      sw1_addr_ff   <= b_ff;
      prod_ff       <= PW'(h_rdata) * PW'(h_rdata - HIST_W'(1));
      rsp_pair_ff   <= rsp_pair_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pair_count = rsp_pair_ff;
   assign rsp_status     = rsp_status_ff;

`ifndef NO_ASSERTIONS
   a_walk_needs_two: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> (count_ff >= CW'(2)))
      else $error("interval walk with fewer than two words");

   a_sweep_after_drain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP) |-> (!s1_vld_ff && !s2_vld_ff))
      else $error("histogram sweep overlaps interval updates");

   a_error_zero_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != STATUS_OK)) |-> (rsp_pair_ff == '0))
      else $error("nonzero pair count with error status");

   a_emit_holds_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> $stable(rsp_pair_ff) && $stable(rsp_status_ff))
      else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire

// File: bench/tb_equal_sum_interval_pair_counter_unit.sv
`timescale 1ns / 1ps

module tb_equal_sum_interval_pair_counter_unit;
   import esipc_pkg::*;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [VALUE_PORT_W-1:0] req_value = '0;
   logic                    req_last = 1'b0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [PAIR_W-1:0]       rsp_pair_count;
   logic [STATUS_W-1:0]     rsp_status;

   localparam int MAX_WORDS = MAX_ITEMS_DEF;
   localparam int SUM_LIMIT = HIST_DEPTH_DEF;

   equal_sum_interval_pair_counter_unit i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_value(req_value), .req_last(req_last),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_pair_count(rsp_pair_count), .rsp_status(rsp_status)
   );

   always #5 clock = ~clock;

   int idle_pct  = 0;
   int stall_pct = 0;
   int mismatches = 0;
   int words_sent = 0;

   // running sequence as the block sees it
   longint unsigned prefix_sums[$];
   bit              seq_too_long = 0;
   bit              seq_overflow = 0;

   logic [PAIR_W-1:0]   expected_counts[$];
   logic [STATUS_W-1:0] expected_status[$];

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $time, what);
      mismatches++;
   endtask

   function automatic logic [PAIR_W-1:0] count_equal_pairs();
      int unsigned     sum_bins[longint unsigned];
      longint unsigned total;
      longint unsigned s;
      longint unsigned k;
      total = 0;
      for (int i = 0; i < prefix_sums.size(); i++) begin
         for (int j = i + 1; j < prefix_sums.size(); j++) begin
            s = prefix_sums[j] - ((i == 0) ? 0 : prefix_sums[i-1]);
            if (s < SUM_LIMIT) begin
               if (sum_bins.exists(s)) sum_bins[s] = (sum_bins[s] + 1) & 32'h3f_ffff;
               else sum_bins[s] = 1;
            end
         end
      end
      foreach (sum_bins[b]) begin
         k = sum_bins[b];
         if (k > 1) total = (total + k * (k - 1) / 2) & ((64'd1 << TOTAL_W) - 1);
      end
      return total[PAIR_W-1:0];
   endfunction

   function automatic void accept_word(input logic [VALUE_PORT_W-1:0] v, input logic l);
      longint unsigned p;
      if (prefix_sums.size() >= MAX_WORDS) begin
         seq_too_long = 1;
      end else begin
         p = (prefix_sums.size() == 0) ? v : prefix_sums[$] + v;
         prefix_sums.push_back(p);
         if (p > SUM_LIMIT - 1) seq_overflow = 1;
      end
      if (!l) return;
      if (seq_too_long) begin
         expected_counts.push_back('0);
         expected_status.push_back(STATUS_TOO_LONG);
      end else if (seq_overflow) begin
         expected_counts.push_back('0);
         expected_status.push_back(STATUS_SUM_OVF);
      end else begin
         expected_counts.push_back(count_equal_pairs());
         expected_status.push_back(STATUS_OK);
      end
      prefix_sums.delete();
      seq_too_long = 0;
      seq_overflow = 0;
   endfunction

   task automatic send_word(input logic [VALUE_PORT_W-1:0] v, input logic l);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= v;
      req_last  <= l;
      do @(posedge clock); while (!req_ready);
      accept_word(v, l);
      words_sent++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_counts.size() == 0) begin
            report_mismatch("result word with nothing expected");
         end else begin
            if (rsp_pair_count !== expected_counts[0])
               report_mismatch($sformatf("pair_count %0d, expected %0d",
                                         rsp_pair_count, expected_counts[0]));
            if (rsp_status !== expected_status[0])
               report_mismatch($sformatf("status %0d, expected %0d",
                                         rsp_status, expected_status[0]));
            void'(expected_counts.pop_front());
            void'(expected_status.pop_front());
         end
      end
      if (!reset) rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   task automatic set_idling(input int mode);
      case (mode % 4)
         0: begin idle_pct = 0;  stall_pct = 0;  end
         1: begin idle_pct = 50; stall_pct = 0;  end
         2: begin idle_pct = 0;  stall_pct = 50; end
         default: begin idle_pct = 28; stall_pct = 28; end
      endcase
   endtask

   task automatic send_ok_sequence(input int len, input bit tight);
      int budget;
      logic [VALUE_PORT_W-1:0] v;
      budget = SUM_LIMIT - 1;
      for (int i = 0; i < len; i++) begin
         v = tight ? VALUE_PORT_W'($urandom_range(3))
                   : VALUE_PORT_W'($urandom_range(budget / (len - i)));
         budget -= v;
         send_word(v, i == len - 1);
      end
   endtask

   task automatic test_single_word();
      set_idling(0);
      send_word(16'd0, 1'b1);
      send_word(16'hffff, 1'b1);
   endtask

   task automatic test_extremes();
      set_idling(3);
      send_word(16'd1, 1'b0);
      send_word(16'd2, 1'b1);
      send_word(16'h8000, 1'b0);
      send_word(16'h7fff, 1'b1);
      send_word(16'hffff, 1'b0);
      send_word(16'd1, 1'b1);
      send_word(16'hffff, 1'b0);
      send_word(16'hffff, 1'b0);
      send_word(16'h0000, 1'b1);
   endtask

   task automatic test_zero_run();
      set_idling(2);
      for (int i = 0; i < 300; i++) send_word(16'd0, i == 299);
   endtask

   task automatic test_too_long();
      set_idling(1);
      for (int i = 0; i <= MAX_WORDS; i++)
         send_word(VALUE_PORT_W'($urandom_range(1)), i == MAX_WORDS);
      set_idling(0);
      for (int i = 0; i <= MAX_WORDS + 2; i++)
         send_word(VALUE_PORT_W'($urandom), i == MAX_WORDS + 2);
   endtask

   task automatic test_random();
      int ok_left;
      int len;
      ok_left = 10;
      while (words_sent < 1200 + 2 * MAX_WORDS) begin
         set_idling(words_sent / 150);
         if (ok_left > 0 && $urandom_range(9) == 0) begin
            send_ok_sequence($urandom_range(2, 40), 1'($urandom_range(1)));
            ok_left--;
         end else begin
            len = $urandom_range(2, 8);
            for (int i = 0; i < len; i++)
               send_word(VALUE_PORT_W'((i < 2) ? ($urandom | 32'h8000) : $urandom),
                         i == len - 1);
         end
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_single_word();
      test_extremes();
      test_zero_run();
      test_too_long();
      test_random();
      req_valid <= 1'b0;
      while (expected_counts.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0)
         $display("equal_sum_interval_pair_counter_unit regression: pass");
      else
         $display("equal_sum_interval_pair_counter_unit regression: fail");
      $finish;
   end

   initial begin
      #60_000_000;
      $display("equal_sum_interval_pair_counter_unit regression: fail");
      $finish;
   end

endmodule

// File: equal_sum_interval_pair_counter_unit.f
rtl/esipc_pkg.sv
rtl/esipc_prefix_mem.sv
rtl/esipc_hist_mem.sv
rtl/equal_sum_interval_pair_counter_unit.sv
bench/tb_equal_sum_interval_pair_counter_unit.sv
